/* rtl/core/dependency_group_table_unit_macros.svh */
// Assertion macros shared by the dependency group table RTL.
`ifndef DEPENDENCY_GROUP_TABLE_UNIT_MACROS_SVH
`define DEPENDENCY_GROUP_TABLE_UNIT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define DGT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define DGT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its cause.
`define DGT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dgt_pkg.sv */
// Shared constants for the dependency group table.
`default_nettype none
package dgt_pkg;
   localparam int TABLE_SLOTS    = 64;
   localparam int PENDING_GROUPS = 16;
   localparam int LABEL_BITS     = 32;
   localparam int KEY_W          = 256;
   localparam int SLOT_W         = $clog2(TABLE_SLOTS);
   localparam int PEND_IDX_W     = $clog2(PENDING_GROUPS);
   localparam int PEND_CNT_W     = $clog2(PENDING_GROUPS + 1);
   // A fresh label steps at most this many times past labels in use.
   localparam int GUARD          = TABLE_SLOTS + 2;
   localparam int FRESH_W        = GUARD - 1;
   localparam int STEP_W         = $clog2(GUARD + 1);

   localparam logic [2:0] KIND_PREVOUT = 3'd0;
   localparam logic [2:0] KIND_ADD     = 3'd1;
   localparam logic [2:0] KIND_REMOVE  = 3'd2;
   localparam logic [2:0] KIND_LIST    = 3'd3;
   localparam logic [2:0] KIND_SELFISH = 3'd4;
   localparam logic [2:0] KIND_CLEAR   = 3'd5;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_KNOWN     = 3'd1;
   localparam logic [2:0] STAT_NO_GROUP  = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_TOO_MANY  = 3'd4;
endpackage
`default_nettype wire

/* rtl/core/dependency_group_table_unit.sv */
// Top level of the dependency group table.
`default_nettype none
`include "dependency_group_table_unit_macros.svh"
// Usage:
// An item is taken when start is high and busy is low. Its kind selects a
// prevout lookup, an add, a group removal, a group listing, a selfish check
// or a clear. Results appear on the rsp_ ports for one cycle, marked by
// rsp_strobe; the receiver cannot stall, and the block never needs it to.
// The age register is written through csr_write_enable and csr_write_data;
// the user must write it only while the block is idle; the block does not enforce it.
// A clear is handled while idle and answers in the next cycle. Every other
// kind makes one pass over all table slots through the slot memories. An add
// that merges several groups makes a second relabeling pass of the same
// length and then writes the new key in the write state.
// A listing streams its members during the pass, at most one per cycle.
// Kinds 6 and 7 are dropped on acceptance.
// Reset empties the table and the pending set and zeroes the label counter
// and the age register; no clearing pass is needed.
module dependency_group_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_kind,
   input  wire logic [63:0] req_key_part_0,
   input  wire logic [63:0] req_key_part_1,
   input  wire logic [63:0] req_key_part_2,
   input  wire logic [63:0] req_key_part_3,
   input  wire logic        req_hint_valid,
   input  wire logic [31:0] req_group_select,
   input  wire logic [31:0] req_stamp_or_now,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_group_result,
   output logic [63:0]      rsp_member_part_0,
   output logic [63:0]      rsp_member_part_1,
   output logic [63:0]      rsp_member_part_2,
   output logic [63:0]      rsp_member_part_3,
   output logic             rsp_last,
   output logic             rsp_selfish
);
   localparam int N   = dgt_pkg::TABLE_SLOTS;
   localparam int P   = dgt_pkg::PENDING_GROUPS;
   localparam int LW  = dgt_pkg::LABEL_BITS;
   localparam int KW  = dgt_pkg::KEY_W;
   localparam int SW  = dgt_pkg::SLOT_W;
   localparam int FW  = dgt_pkg::FRESH_W;
   localparam int KSW = dgt_pkg::STEP_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  op_ff;
   logic [KW-1:0] key_ff;
   logic [31:0] sel_ff, stamp_ff, age_ff;
   logic [SW-1:0] idx_ff, didx_ff, free_ff;
   logic        dvld_ff, relabel_ff;
   logic        key_hit_ff, hint_fail_ff, found_ff, all_ff;
   logic [LW-1:0] hit_lab_ff, new_lab_ff, next_lab_ff;
   logic [P-1:0]  grp_hit_ff;
   logic [FW-1:0] used_ff;
   logic [KW-1:0] held_ff;
   logic [N-1:0]  valid_ff;
   logic [31:0]   pend_ff [P];
   logic [dgt_pkg::PEND_CNT_W-1:0] pend_cnt_ff;
   logic          pend_ovf_ff;

   logic          rsp_strobe_ff, rsp_last_ff, rsp_selfish_ff;
   logic [2:0]    rsp_status_ff;
   logic [31:0]   rsp_group_ff;
   logic [KW-1:0] rsp_key_ff;

   logic [KW-1:0] rd_key;
   logic [LW-1:0] rd_lab;
   logic [31:0]   rd_stamp;

   // Memory write side.
   logic          key_we, lab_we;
   logic [SW-1:0] lab_waddr;

   assign key_we    = (state_ff == S_WRITE);
   assign lab_we    = key_we || (relabel_ff && slot_live && (|pend_match));
   assign lab_waddr = key_we ? free_ff : didx_ff;

   dgt_ram #(.WIDTH(KW), .DEPTH(N)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(free_ff), .wr_data(key_ff),
      .rd_addr(idx_ff), .rd_data(rd_key)
   );
   dgt_ram #(.WIDTH(LW), .DEPTH(N)) u_label_ram (
      .clock(clock), .wr_en(lab_we), .wr_addr(lab_waddr), .wr_data(new_lab_ff),
      .rd_addr(idx_ff), .rd_data(rd_lab)
   );
   dgt_ram #(.WIDTH(32), .DEPTH(N)) u_stamp_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(free_ff), .wr_data(stamp_ff),
      .rd_addr(idx_ff), .rd_data(rd_stamp)
   );

   // Per-slot view of the data returned by the memories.
   logic          slot_live, key_eq, sel_eq, older;
   logic [P-1:0]  pend_match, pend_live;
   logic [LW-1:0] offset;
   logic signed [33:0] cutoff;

   assign slot_live = dvld_ff && valid_ff[didx_ff];
   assign key_eq    = (rd_key == key_ff);
   assign sel_eq    = (32'(rd_lab) == sel_ff);
   assign offset    = rd_lab - next_lab_ff - LW'(1);
   assign cutoff    = $signed({2'b00, stamp_ff}) - $signed({2'b00, age_ff});
   assign older     = $signed({2'b00, rd_stamp}) < cutoff;

   always_comb begin
      for (int i = 0; i < P; i++) begin
         pend_live[i]  = (i < int'(pend_cnt_ff));
         pend_match[i] = pend_live[i] && (pend_ff[i] == 32'(rd_lab));
      end
   end

   // Pending set insertion: new item hint while idle, found label at the end.
   logic [31:0] pa_lab;
   logic        pa_hit, pa_full;

   assign pa_lab  = (state_ff == S_IDLE) ? req_group_select : 32'(hit_lab_ff);
   assign pa_full = (pend_cnt_ff == dgt_pkg::PEND_CNT_W'(P));

   always_comb begin
      pa_hit = 1'b0;
      for (int i = 0; i < P; i++) begin
         if (pend_live[i] && (pend_ff[i] == pa_lab)) begin
            pa_hit = 1'b1;
         end
      end
   end

   // Lowest free slot.
   logic [SW-1:0] free_idx;
   logic          table_full;

   assign table_full = &valid_ff;

   always_comb begin
      free_idx = '0;
      for (int s = N - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_idx = SW'(s);
         end
      end
   end

   // Step count of the label counter past labels in use.
   logic [KSW-1:0] step;

   always_comb begin
      step = KSW'(dgt_pkg::GUARD);
      for (int k = FW - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            step = KSW'(k + 1);
         end
      end
   end

   // Outcome of an add, checked in priority order.
   logic [2:0] add_status;

   always_comb begin
      if (key_hit_ff) begin
         add_status = dgt_pkg::STAT_KNOWN;
      end else if (hint_fail_ff || pend_ovf_ff) begin
         add_status = dgt_pkg::STAT_TOO_MANY;
      end else if (|(pend_live & ~grp_hit_ff)) begin
         add_status = dgt_pkg::STAT_NO_GROUP;
      end else if (table_full) begin
         add_status = dgt_pkg::STAT_FULL;
      end else begin
         add_status = dgt_pkg::STAT_OK;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && (req_kind inside {dgt_pkg::KIND_PREVOUT, dgt_pkg::KIND_ADD,
                                          dgt_pkg::KIND_REMOVE, dgt_pkg::KIND_LIST,
                                          dgt_pkg::KIND_SELFISH})) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == SW'(N - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = relabel_ff ? S_WRITE : S_FIN;
         S_FIN: begin
            state_in = S_IDLE;
            if (op_ff == dgt_pkg::KIND_ADD && add_status == dgt_pkg::STAT_OK) begin
               if (pend_cnt_ff >= dgt_pkg::PEND_CNT_W'(2)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         next_lab_ff   <= '0;
         pend_cnt_ff   <= '0;
         pend_ovf_ff   <= 1'b0;
         age_ff        <= '0;
         dvld_ff       <= 1'b0;
         relabel_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dvld_ff       <= (state_ff == S_SCAN);
         rsp_strobe_ff <= 1'b0;
         if (csr_write_enable) begin
            age_ff <= csr_write_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start && req_kind == dgt_pkg::KIND_CLEAR) begin
                  valid_ff      <= '0;
                  next_lab_ff   <= '0;
                  pend_cnt_ff   <= '0;
                  pend_ovf_ff   <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
               end else if (start && req_kind == dgt_pkg::KIND_ADD && req_hint_valid &&
                            !pa_hit && !pa_full) begin
                  pend_cnt_ff <= pend_cnt_ff + 1'b1;
               end
            end
            S_DRAIN, S_SCAN: begin
               // Remove clears each member's valid bit as the pass meets it.
               if (op_ff == dgt_pkg::KIND_REMOVE && slot_live && sel_eq) begin
                  valid_ff[didx_ff] <= 1'b0;
               end
               if (op_ff == dgt_pkg::KIND_LIST && slot_live && sel_eq && found_ff) begin
                  rsp_strobe_ff <= 1'b1;
               end
            end
            S_FIN: begin
               case (op_ff)
                  dgt_pkg::KIND_PREVOUT: begin
                     if (key_hit_ff && !pa_hit) begin
                        if (pa_full) begin
                           pend_ovf_ff <= 1'b1;
                        end else begin
                           pend_cnt_ff <= pend_cnt_ff + 1'b1;
                        end
                     end
                  end
                  dgt_pkg::KIND_ADD: begin
                     if (add_status != dgt_pkg::STAT_OK) begin
                        pend_cnt_ff   <= '0;
                        pend_ovf_ff   <= 1'b0;
                        rsp_strobe_ff <= 1'b1;
                     end else begin
                        if (pend_cnt_ff != dgt_pkg::PEND_CNT_W'(1)) begin
                           next_lab_ff <= next_lab_ff + LW'(step);
                        end
                        relabel_ff <= (pend_cnt_ff >= dgt_pkg::PEND_CNT_W'(2));
                     end
                  end
                  default: rsp_strobe_ff <= 1'b1;
               endcase
            end
            S_WRITE: begin
               valid_ff[free_ff] <= 1'b1;
               pend_cnt_ff       <= '0;
               pend_ovf_ff       <= 1'b0;
               relabel_ff        <= 1'b0;
               rsp_strobe_ff     <= 1'b1;
            end
            default: begin
               relabel_ff <= 1'b0;
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      didx_ff <= idx_ff;
      if (state_ff == S_SCAN) begin
         idx_ff <= idx_ff + 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            idx_ff       <= '0;
            op_ff        <= req_kind;
            key_ff       <= {req_key_part_3, req_key_part_2, req_key_part_1, req_key_part_0};
            sel_ff       <= req_group_select;
            stamp_ff     <= req_stamp_or_now;
            key_hit_ff   <= 1'b0;
            found_ff     <= 1'b0;
            all_ff       <= 1'b1;
            grp_hit_ff   <= '0;
            used_ff      <= '0;
            hint_fail_ff <= req_hint_valid && !pa_hit && pa_full;
            if (start && req_kind == dgt_pkg::KIND_ADD && req_hint_valid &&
                !pa_hit && !pa_full) begin
               pend_ff[pend_cnt_ff[dgt_pkg::PEND_IDX_W-1:0]] <= req_group_select;
            end
            rsp_status_ff  <= dgt_pkg::STAT_OK;
            rsp_group_ff   <= '0;
            rsp_key_ff     <= '0;
            rsp_last_ff    <= 1'b1;
            rsp_selfish_ff <= 1'b0;
         end
         S_SCAN, S_DRAIN: begin
            if (slot_live && !relabel_ff) begin
               if (key_eq && !key_hit_ff) begin
                  key_hit_ff <= 1'b1;
                  hit_lab_ff <= rd_lab;
               end
               grp_hit_ff <= grp_hit_ff | pend_match;
               if (offset < LW'(FW)) begin
                  used_ff[offset[KSW-1:0]] <= 1'b1;
               end
               if (sel_eq) begin
                  found_ff <= 1'b1;
                  held_ff  <= rd_key;
                  if (!older) begin
                     all_ff <= 1'b0;
                  end
                  // A listed member goes out once the next one is known.
                  rsp_status_ff <= dgt_pkg::STAT_OK;
                  rsp_group_ff  <= sel_ff;
                  rsp_key_ff    <= held_ff;
                  rsp_last_ff   <= 1'b0;
               end
            end
         end
         S_FIN: begin
            free_ff        <= free_idx;
            rsp_last_ff    <= 1'b1;
            rsp_key_ff     <= '0;
            rsp_group_ff   <= '0;
            rsp_selfish_ff <= 1'b0;
            rsp_status_ff  <= found_ff ? dgt_pkg::STAT_OK : dgt_pkg::STAT_NO_GROUP;
            if (pend_cnt_ff == dgt_pkg::PEND_CNT_W'(1)) begin
               new_lab_ff <= pend_ff[0][LW-1:0];
            end else begin
               new_lab_ff <= next_lab_ff;
            end
            if (op_ff == dgt_pkg::KIND_PREVOUT && key_hit_ff && !pa_hit && !pa_full) begin
               pend_ff[pend_cnt_ff[dgt_pkg::PEND_IDX_W-1:0]] <= 32'(hit_lab_ff);
            end
            case (op_ff)
               dgt_pkg::KIND_ADD: rsp_status_ff <= add_status;
               dgt_pkg::KIND_LIST: begin
                  if (found_ff) begin
                     rsp_group_ff <= sel_ff;
                     rsp_key_ff   <= held_ff;
                  end
               end
               dgt_pkg::KIND_SELFISH: rsp_selfish_ff <= found_ff && all_ff;
               default: rsp_last_ff <= 1'b1;
            endcase
         end
         S_WRITE: begin
            rsp_status_ff  <= dgt_pkg::STAT_OK;
            rsp_group_ff   <= 32'(new_lab_ff);
            rsp_key_ff     <= '0;
            rsp_last_ff    <= 1'b1;
            rsp_selfish_ff <= 1'b0;
         end
         default: begin
            idx_ff <= '0;
         end
      endcase
      if (state_ff == S_FIN && state_in == S_SCAN) begin
         idx_ff <= '0;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_group_result  = rsp_group_ff;
   assign rsp_member_part_0 = rsp_key_ff[63:0];
   assign rsp_member_part_1 = rsp_key_ff[127:64];
   assign rsp_member_part_2 = rsp_key_ff[191:128];
   assign rsp_member_part_3 = rsp_key_ff[255:192];
   assign rsp_last          = rsp_last_ff;
   assign rsp_selfish       = rsp_selfish_ff;

   // Checks.
   `DGT_ASSERT_ALWAYS(a_pend_bound, pend_cnt_ff <= dgt_pkg::PEND_CNT_W'(P), "pending set overrun")
   `DGT_ASSERT_IMPL(a_list_inflight, rsp_strobe_ff && !rsp_last_ff, state_ff == S_SCAN || state_ff == S_DRAIN || state_ff == S_FIN, "non-final item outside a listing pass")
   `DGT_ASSERT_NEXT(a_one_insert, 1'b1, $countones(valid_ff) <= $countones($past(valid_ff)) + 1, "more than one slot filled at once")
endmodule
`default_nettype wire

/* rtl/core/dgt_ram.sv */
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module dgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // At most one write, when wr_en is high, and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
